>>> src/top_five_ranking_composite_key_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the top-five ranking block.
// ---------------------------------------------------------------------------
`ifndef TOP_FIVE_RANKING_COMPOSITE_KEY_DEFINES_SVH
`define TOP_FIVE_RANKING_COMPOSITE_KEY_DEFINES_SVH

// Clocked property that is not checked while reset is asserted.
`define TFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that is checked in every cycle, reset included.
`define TFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/tfrck_pkg.sv
// ---------------------------------------------------------------------------
// tfrck_pkg
// Shared widths, defaults and controller/datapath interface types.
// ---------------------------------------------------------------------------
package tfrck_pkg;

    localparam int SCORE_W           = 8;
    localparam int TOTAL_W           = 10;
    localparam int DEF_TOP_COUNT     = 5;
    localparam int DEF_MAX_RECORDS   = 64;

    typedef struct packed {
        logic insert;
        logic pop;
        logic clear;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_last;
    } t_dp_status;

endpackage

>>> src/tfrck_dp.sv
// ---------------------------------------------------------------------------
// tfrck_dp
// Ranking datapath: sorted entry row with parallel compare, insertion shift,
// record counter, overflow flag and the output register.
// ---------------------------------------------------------------------------
module tfrck_dp #(
    parameter int TOP_COUNT   = 5,
    parameter int MAX_RECORDS = 64,
    localparam int NUM_W      = $clog2(MAX_RECORDS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tfrck_pkg::t_ctrl_cmd           i_cmd,
    input  logic [tfrck_pkg::SCORE_W-1:0]  i_s1,
    input  logic [tfrck_pkg::SCORE_W-1:0]  i_s2,
    input  logic [tfrck_pkg::SCORE_W-1:0]  i_s3,
    output tfrck_pkg::t_dp_status          o_status,
    output logic [NUM_W-1:0]               o_num,
    output logic [tfrck_pkg::TOTAL_W-1:0]  o_total,
    output logic                           o_ovf
);
    import tfrck_pkg::*;

    localparam logic [NUM_W-1:0] MAX_CNT = NUM_W'(MAX_RECORDS);

    logic [NUM_W-1:0]   r_num [TOP_COUNT];
    logic [TOTAL_W-1:0] r_tot [TOP_COUNT];
    logic [SCORE_W-1:0] r_fst [TOP_COUNT];
    logic [TOP_COUNT-1:0] r_vld;
    logic [NUM_W-1:0]   r_cnt;
    logic               r_ovf;

    logic [NUM_W-1:0]   r_out_num;
    logic [TOTAL_W-1:0] r_out_tot;
    logic               r_out_last;
    logic               r_out_ovf;

    logic [TOTAL_W-1:0] w_total;
    logic [NUM_W-1:0]   w_number;
    logic               w_full;
    logic [TOP_COUNT-1:0] w_above;
    logic [TOP_COUNT:0]   w_above_ext;
    logic [TOP_COUNT:0]   w_vld_ext;
    logic [TOP_COUNT:0]   w_prev_vld;
    logic [NUM_W-1:0]   w_prev_num [TOP_COUNT];
    logic [TOTAL_W-1:0] w_prev_tot [TOP_COUNT];
    logic [SCORE_W-1:0] w_prev_fst [TOP_COUNT];

    assign w_total  = TOTAL_W'(i_s1) + TOTAL_W'(i_s2) + TOTAL_W'(i_s3);
    assign w_number = r_cnt + 1'b1;
    assign w_full   = (r_cnt == MAX_CNT);
    assign w_vld_ext = {1'b0, r_vld};

    // A new record always carries the highest arrival number, so it ranks above a
    // kept entry only when its {total, first score} key is strictly larger.
    always_comb begin
        w_above_ext    = '0;
        w_prev_vld     = '0;
        w_prev_num[0]  = '0;
        w_prev_tot[0]  = '0;
        w_prev_fst[0]  = '0;
        for (int i = 0; i < TOP_COUNT; i++) begin
            w_above[i] = !r_vld[i] || ({w_total, i_s1} > {r_tot[i], r_fst[i]});
            w_above_ext[i+1] = w_above[i];
            w_prev_vld[i+1]  = r_vld[i];
        end
        for (int i = 1; i < TOP_COUNT; i++) begin
            w_prev_num[i] = r_num[i-1];
            w_prev_tot[i] = r_tot[i-1];
            w_prev_fst[i] = r_fst[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !w_full) begin
            for (int i = 0; i < TOP_COUNT; i++) begin
                if (w_above[i]) begin
                    if (!w_above_ext[i]) begin
                        r_num[i] <= w_number;
                        r_tot[i] <= w_total;
                        r_fst[i] <= i_s1;
                    end else begin
                        r_num[i] <= w_prev_num[i];
                        r_tot[i] <= w_prev_tot[i];
                        r_fst[i] <= w_prev_fst[i];
                    end
                end
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < TOP_COUNT - 1; i++) begin
                r_num[i] <= r_num[i+1];
                r_tot[i] <= r_tot[i+1];
                r_fst[i] <= r_fst[i+1];
            end
        end
        if (i_cmd.pop) begin
            r_out_num  <= r_num[0];
            r_out_tot  <= r_tot[0];
            r_out_last <= !w_vld_ext[1];
            r_out_ovf  <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.clear) begin
            r_vld <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.insert) begin
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_cnt <= w_number;
                for (int i = 0; i < TOP_COUNT; i++) begin
                    if (w_above[i]) begin
                        r_vld[i] <= w_above_ext[i] ? w_prev_vld[i] : 1'b1;
                    end
                end
            end
        end else if (i_cmd.pop) begin
            r_vld <= w_vld_ext[TOP_COUNT:1];
        end
    end

    assign o_status.out_last = r_out_last;
    assign o_num             = r_out_num;
    assign o_total           = r_out_tot;
    assign o_ovf             = r_out_ovf;

endmodule

>>> src/tfrck_ctrl.sv
// ---------------------------------------------------------------------------
// tfrck_ctrl
// Controller: accepts records, then pops the ranked entries one transaction
// at a time into the output register.
// ---------------------------------------------------------------------------
`include "top_five_ranking_composite_key_defines.svh"

module tfrck_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_last,
    input  logic                   i_out_ready,
    input  tfrck_pkg::t_dp_status  i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output tfrck_pkg::t_ctrl_cmd   o_cmd
);
    import tfrck_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.insert = i_in_valid && o_in_ready;
        o_cmd.pop    = (r_state == S_EMIT) &&
                       (!r_out_valid || (i_out_ready && !i_status.out_last));
        o_cmd.clear  = (r_state == S_EMIT) && r_out_valid && i_out_ready &&
                       i_status.out_last;
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.insert && i_in_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_cmd.clear) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                end else if (o_cmd.pop) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `TFR_ASSERT(a_insert_pop_exclusive, i_clk, i_rst_n, !(o_cmd.insert && o_cmd.pop), "insert and pop in the same cycle")
    `TFR_ASSERT(a_valid_only_emit, i_clk, i_rst_n, r_out_valid |-> (r_state == S_EMIT), "output valid outside emission")
    `TFR_ASSERT(a_last_starts_emit, i_clk, i_rst_n, (o_cmd.insert && i_in_last) |=> ((r_state == S_EMIT) && !r_out_valid), "last record did not start emission")
    `TFR_ASSERT(a_clear_returns_idle, i_clk, i_rst_n, o_cmd.clear |=> ((r_state == S_IDLE) && !r_out_valid), "final transaction did not return to idle")

endmodule

>>> src/top_five_ranking_composite_key.sv
// Each accepted record is ranked in the cycle it is accepted; one record per cycle.
// The parallel compare of the new key against every kept entry sets that cycle.
// After the last record, the controller loads the output register, then one ranked
// entry leaves per cycle while m_axis_tready is high; no record is taken meanwhile.
// Synchronous active-low reset empties the ranking and clears count and overflow.
// ---------------------------------------------------------------------------
// top_five_ranking_composite_key
// Keeps the best records by total, first score and arrival number, and
// emits the ranking when the last record of a set arrives.
// ---------------------------------------------------------------------------
module top_five_ranking_composite_key #(
    parameter int TOP_COUNT   = tfrck_pkg::DEF_TOP_COUNT,
    parameter int MAX_RECORDS = tfrck_pkg::DEF_MAX_RECORDS,
    localparam int NUM_W      = $clog2(MAX_RECORDS + 1),
    localparam int M_DATA_W   = ((NUM_W + tfrck_pkg::TOTAL_W + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // first_subject_score, second_subject_score, third_subject_score
    input  logic [23:0]         s_axis_tdata,
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // record_number, record_total, zero fill
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tlast,
    // overflowed
    output logic                m_axis_tuser
);
    import tfrck_pkg::*;

    t_ctrl_cmd          w_cmd;
    t_dp_status         w_status;
    logic [NUM_W-1:0]   w_num;
    logic [TOTAL_W-1:0] w_total;
    logic               w_ovf;

    tfrck_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    tfrck_dp #(
        .TOP_COUNT   (TOP_COUNT),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_s1     (s_axis_tdata[7:0]),
        .i_s2     (s_axis_tdata[15:8]),
        .i_s3     (s_axis_tdata[23:16]),
        .o_status (w_status),
        .o_num    (w_num),
        .o_total  (w_total),
        .o_ovf    (w_ovf)
    );

    assign m_axis_tdata = M_DATA_W'({w_total, w_num});
    assign m_axis_tlast = w_status.out_last;
    assign m_axis_tuser = w_ovf;

endmodule
